// ===== design/todc_pkg.sv =====
// Package for the time-of-day counter with alarm.
// Holds action codes, byte select codes, register addresses and result type.
// No dependencies.
package todc_pkg;

    localparam int unsigned CountW = 24;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CountW-1:0] CountReset = 24'h010000;
    localparam logic [11:0] LowCarryMask = 12'hFFF;
    localparam logic [CountW-1:0] MidHighInc = 24'h001000;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_WR_COUNT  = 3'd1,
        ACT_WR_ALARM  = 3'd2,
        ACT_RD_COUNT  = 3'd3,
        ACT_RD_ALARM  = 3'd4,
        ACT_SET_STOP  = 3'd5,
        ACT_FREEZE    = 3'd6,
        ACT_UNFREEZE  = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        SEL_LOW  = 2'd0,
        SEL_MID  = 2'd1,
        SEL_HIGH = 2'd2,
        SEL_NONE = 2'd3
    } t_byte_sel;

    localparam logic [CfgAddrW-1:0] ADDR_BUG_MODE = 3'd0;

    typedef struct packed {
        logic              alarm_irq;
        logic [ByteW-1:0]  read_data;
    } t_result;

    // Replace one byte of a 24-bit word; select three leaves the word as is.
    function automatic logic [CountW-1:0] put_byte(input logic [CountW-1:0] word,
                                                   input t_byte_sel sel,
                                                   input logic [ByteW-1:0] b);
        logic [CountW-1:0] w;
        w = word;
        unique case (sel)
            SEL_LOW:  w[7:0]   = b;
            SEL_MID:  w[15:8]  = b;
            SEL_HIGH: w[23:16] = b;
            default:  w = word;
        endcase
        return w;
    endfunction

    function automatic logic [ByteW-1:0] get_byte(input logic [CountW-1:0] word,
                                                  input t_byte_sel sel);
        logic [ByteW-1:0] b;
        b = '0;
        unique case (sel)
            SEL_LOW:  b = word[7:0];
            SEL_MID:  b = word[15:8];
            SEL_HIGH: b = word[23:16];
            default:  b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== design/tod_counter_with_alarm.sv =====
// Time-of-day counter with alarm: one word in, one result word out per word.
// Each accepted word is handled in the cycle it is taken; the result lands in a
// two-entry output buffer (output register plus skid), so s_tready only drops
// when both entries are full. Sustained rate is one word per clock while m_tready
// stays high; each result is registered in the output register or, if full, the
// skid. Counter, alarm and edge detector update on acceptance; needs todc_pkg.
module tod_counter_with_alarm
    import todc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] write_data
    input  logic [4:0]          s_tuser,   // [2:0] action, [4:3] byte_sel
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] read_data, [8] alarm_irq, rest zero
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    logic [CountW-1:0] r_count, n_count;
    logic [CountW-1:0] r_alarm, n_alarm;
    logic [CountW-1:0] r_latch, n_latch;
    logic              r_stopped, n_stopped;
    logic              r_frozen, n_frozen;
    logic              r_matching, n_matching;
    logic              r_bug_mode;

    t_result           r_out, r_skid, n_res;
    logic              r_out_valid, r_skid_valid;

    t_action           act;
    t_byte_sel         sel;
    logic [ByteW-1:0]  wdata;
    logic              s_accept, m_taken, cfg_wr;

    // intermediate tick values
    logic [CountW-1:0] tick_mid, tick_next;
    logic              carry12, mid_eq, mid_fire, wm_mid, fin_eq;

    assign act      = t_action'(s_tuser[2:0]);
    assign sel      = t_byte_sel'(s_tuser[4:3]);
    assign wdata    = s_tdata;
    assign s_tready = !r_skid_valid;
    assign s_accept = s_tvalid && s_tready;
    assign m_taken  = r_out_valid && m_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_BUG_MODE);
    assign prdata = (paddr == ADDR_BUG_MODE) ? {{(CfgDataW-1){1'b0}}, r_bug_mode} : '0;

    // Tick path: when the low 12 bits are all ones, the bug mode checks the
    // value with those bits cleared before the mid high nibble increments.
    always_comb begin
        carry12   = (r_count[11:0] == LowCarryMask);
        tick_mid  = {r_count[CountW-1:12], 12'h000};
        tick_next = r_count + CountW'(1);
        mid_eq    = (tick_mid == r_alarm);
        mid_fire  = carry12 && r_bug_mode && mid_eq && !r_matching;
        wm_mid    = (carry12 && r_bug_mode) ? mid_eq : r_matching;
        fin_eq    = (tick_next == r_alarm);
    end

    always_comb begin
        n_count    = r_count;
        n_alarm    = r_alarm;
        n_latch    = r_latch;
        n_stopped  = r_stopped;
        n_frozen   = r_frozen;
        n_matching = r_matching;
        n_res      = '0;
        unique case (act)
            ACT_TICK: begin
                if (!r_stopped) begin
                    n_count         = tick_next;
                    n_matching      = fin_eq;
                    n_res.alarm_irq = mid_fire || (fin_eq && !wm_mid);
                end
            end
            ACT_WR_COUNT: begin
                if (sel != SEL_NONE) begin
                    n_count         = put_byte(r_count, sel, wdata);
                    n_matching      = (n_count == r_alarm);
                    n_res.alarm_irq = n_matching && !r_matching;
                end
            end
            ACT_WR_ALARM: begin
                if (sel != SEL_NONE) begin
                    n_alarm         = put_byte(r_alarm, sel, wdata);
                    n_matching      = (r_count == n_alarm);
                    n_res.alarm_irq = n_matching && !r_matching;
                end
            end
            ACT_RD_COUNT: n_res.read_data = get_byte(r_frozen ? r_latch : r_count, sel);
            ACT_RD_ALARM: n_res.read_data = get_byte(r_alarm, sel);
            ACT_SET_STOP: n_stopped = wdata[0];
            ACT_FREEZE: begin
                n_latch  = r_count;
                n_frozen = 1'b1;
            end
            ACT_UNFREEZE: n_frozen = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CountReset;
            r_alarm    <= '0;
            r_latch    <= '0;
            r_stopped  <= 1'b1;
            r_frozen   <= 1'b0;
            r_matching <= 1'b1;
        end else if (s_accept) begin
            r_count    <= n_count;
            r_alarm    <= n_alarm;
            r_latch    <= n_latch;
            r_stopped  <= n_stopped;
            r_frozen   <= n_frozen;
            r_matching <= n_matching;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bug_mode <= 1'b1;
        end else if (cfg_wr) begin
            r_bug_mode <= pwdata[0];
        end
    end

    // Output register plus skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_taken) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (s_accept) begin
                if (!r_out_valid || m_taken) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (m_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_taken) begin
                r_out <= r_skid;
            end
        end else if (s_accept) begin
            if (!r_out_valid || m_taken) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'b0, r_out.alarm_irq, r_out.read_data};

    // ---- assertions ----
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_stopped_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && act == ACT_TICK && r_stopped) |=> $stable(r_count))
        else $error("counter moved on a tick while stopped");

    a_freeze_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && act == ACT_FREEZE) |=> (r_frozen && r_latch == $past(r_count)))
        else $error("freeze did not load latch");

    a_read_no_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (act == ACT_RD_COUNT || act == ACT_RD_ALARM)) |-> !n_res.alarm_irq)
        else $error("interrupt raised on a read");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_tready) |=> r_out_valid)
        else $error("result dropped while stalled");

endmodule
